/* sv/cle_pkg.sv */
// ----------------------------------------------------------------------------
// Console line editor package
// Shared byte codes, widths and the controller/datapath command and status
// structs.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int BYTE_W  = 8;
  localparam int LIMIT_W = 6;

  localparam logic [BYTE_W-1:0]  CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0]  CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0]  CH_BS = 8'h08;
  localparam logic [BYTE_W-1:0]  CH_SP = 8'h20;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  typedef struct packed {
    logic take_item;
    logic echo_load;
    logic rd_issue;
    logic line_load;
  } cle_cmd_t;

  typedef struct packed {
    logic out_free;
    logic echo_none;
    logic echo_last;
    logic flush_pend;
    logic line_last;
  } cle_sts_t;

endpackage

/* sv/cle_rx_if.sv */
// ----------------------------------------------------------------------------
// Console receive channel
// Carries one received console byte per beat.
// ----------------------------------------------------------------------------
interface cle_rx_if
  import cle_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/cle_tx_if.sv */
// ----------------------------------------------------------------------------
// Console transmit channel
// Carries one echo byte or one byte of a finished line per beat.
// ----------------------------------------------------------------------------
interface cle_tx_if
  import cle_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

/* sv/cle_cfg_if.sv */
// ----------------------------------------------------------------------------
// Console line editor configuration channel
// Each beat writes the line limit register.
// ----------------------------------------------------------------------------
interface cle_cfg_if
  import cle_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] line_limit;

  modport source (output valid, output line_limit, input ready);
  modport sink   (input valid, input line_limit, output ready);
endinterface

/* sv/console_line_editor_core.sv */
// ----------------------------------------------------------------------------
// Console line editor core
// Builds a console line from received bytes with echo and emits the line
// when it ends.
// ----------------------------------------------------------------------------
// An item is taken in S_IDLE, after the previous item's last echo byte is loaded
// or its line has been emitted. An item without line end has up to 3 echo bytes.
// A line end reads each stored byte with a line store read, then an output load.
// A line is emitted on CR or LF, or once an ordinary byte fills it to limit minus one.
// Reset clears the fill count and sets the line limit to 32; the store is not cleared.
// ----------------------------------------------------------------------------
module console_line_editor_core
  import cle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input logic      clk,
  input logic      rst,
  cle_rx_if.sink   rx,
  cle_tx_if.source tx,
  cle_cfg_if.sink  cfg
);

  cle_cmd_t cmd;
  cle_sts_t sts;
  logic     in_ready;

  assign rx.ready = in_ready;

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_dp #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .rx_byte (rx.rx_byte),
    .cmd     (cmd),
    .sts     (sts),
    .tx      (tx),
    .cfg     (cfg)
  );

endmodule

/* sv/cle_ctrl.sv */
// ----------------------------------------------------------------------------
// Console line editor controller
// Sequences input acceptance, echo bytes and the read-out of a finished line.
// ----------------------------------------------------------------------------
module cle_ctrl
  import cle_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  cle_sts_t sts,
  output cle_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ECHO = 4'b0010,
    S_RD   = 4'b0100,
    S_LINE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next = S_ECHO;
        end
      end
      S_ECHO: begin
        if (sts.echo_none) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.echo_load = 1'b1;
          if (sts.echo_last) begin
            state_next = sts.flush_pend ? S_RD : S_IDLE;
          end
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_next = S_LINE;
      end
      S_LINE: begin
        if (sts.out_free) begin
          cmd.line_load = 1'b1;
          state_next = sts.line_last ? S_IDLE : S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> state == S_ECHO)
    else $error("item accepted without entering the echo phase");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.echo_load || cmd.line_load) |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_read_then_line: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |=> state == S_LINE)
    else $error("store read not followed by the line load phase");

endmodule

/* sv/cle_dp.sv */
// ----------------------------------------------------------------------------
// Console line editor datapath
// Line store, fill count, limit register, echo selection and output register.
// ----------------------------------------------------------------------------
module cle_dp
  import cle_pkg::*;
#(
  parameter int LINE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [BYTE_W-1:0] rx_byte,
  input  cle_cmd_t          cmd,
  output cle_sts_t          sts,
  cle_tx_if.source          tx,
  cle_cfg_if.sink           cfg
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int FW = $clog2(LINE_DEPTH + 1);
  localparam int LW = LIMIT_W + 1;

  typedef enum logic [1:0] {
    KIND_ORD = 2'b00,
    KIND_EOL = 2'b01,
    KIND_BS  = 2'b10
  } kind_t;

  logic [BYTE_W-1:0]  line_store [LINE_DEPTH];
  logic [FW-1:0]      fill_count;
  logic [LIMIT_W-1:0] limit;
  logic [BYTE_W-1:0]  item_byte;
  kind_t              item_kind;
  logic [1:0]         echo_len;
  logic [1:0]         echo_idx;
  logic               flush_pend;
  logic [AW-1:0]      rd_ptr;
  logic [BYTE_W-1:0]  rd_data;
  logic               out_valid;
  logic [BYTE_W-1:0]  out_byte;

  kind_t              rx_kind;
  logic [LW-1:0]      eff_limit;
  logic               has_room;
  logic [FW-1:0]      fill_inc;
  logic               ord_flush;
  logic               mem_we;
  logic [BYTE_W-1:0]  mem_wd;
  logic [BYTE_W-1:0]  echo_byte;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (rx_byte == CH_CR || rx_byte == CH_LF) begin
      rx_kind = KIND_EOL;
    end else if (rx_byte == CH_BS) begin
      rx_kind = KIND_BS;
    end else begin
      rx_kind = KIND_ORD;
    end
  end

  always_comb begin
    if (LW'(limit) < LW'(2)) begin
      eff_limit = LW'(2);
    end else if (LW'(limit) > LW'(LINE_DEPTH)) begin
      eff_limit = LW'(LINE_DEPTH);
    end else begin
      eff_limit = LW'(limit);
    end
  end

  assign has_room  = fill_count < FW'(LINE_DEPTH);
  assign fill_inc  = has_room ? fill_count + FW'(1) : fill_count;
  assign ord_flush = LW'(fill_inc) >= eff_limit - LW'(1);

  assign mem_we = cmd.take_item && has_room && (rx_kind != KIND_BS);
  assign mem_wd = (rx_kind == KIND_EOL) ? CH_LF : rx_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[fill_count[AW-1:0]] <= mem_wd;
    end
    if (cmd.rd_issue) begin
      rd_data <= line_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      limit <= cfg.line_limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (cmd.take_item) begin
      case (rx_kind)
        KIND_BS: begin
          if (fill_count != '0) begin
            fill_count <= fill_count - FW'(1);
          end
        end
        default: fill_count <= fill_inc;
      endcase
    end else if (cmd.line_load && sts.line_last) begin
      fill_count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_len   <= '0;
      echo_idx   <= '0;
      flush_pend <= 1'b0;
      rd_ptr     <= '0;
    end else begin
      if (cmd.take_item) begin
        echo_idx <= '0;
        rd_ptr   <= '0;
        case (rx_kind)
          KIND_EOL: begin
            echo_len   <= 2'd3;
            flush_pend <= 1'b1;
          end
          KIND_BS: begin
            echo_len   <= (fill_count != '0) ? 2'd3 : 2'd0;
            flush_pend <= 1'b0;
          end
          default: begin
            echo_len   <= 2'd1;
            flush_pend <= ord_flush;
          end
        endcase
      end
      if (cmd.echo_load) begin
        echo_idx <= echo_idx + 2'd1;
      end
      if (cmd.line_load) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      item_byte <= rx_byte;
      item_kind <= rx_kind;
    end
  end

  always_comb begin
    case (item_kind)
      KIND_EOL: echo_byte = (echo_idx == 2'd2) ? CH_LF : CH_CR;
      KIND_BS:  echo_byte = (echo_idx == 2'd1) ? CH_SP : CH_BS;
      default:  echo_byte = item_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.echo_load || cmd.line_load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.echo_load) begin
      out_byte <= echo_byte;
    end else if (cmd.line_load) begin
      out_byte <= rd_data;
    end
  end

  assign tx.valid    = out_valid;
  assign tx.out_byte = out_byte;

  assign sts.out_free   = !out_valid || tx.ready;
  assign sts.echo_none  = (echo_len == 2'd0);
  assign sts.echo_last  = (echo_idx == echo_len - 2'd1);
  assign sts.flush_pend = flush_pend;
  assign sts.line_last  = (FW'(rd_ptr) + FW'(1) == fill_count);

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count < FW'(LINE_DEPTH))
    else $error("fill count reached the store depth");

  a_line_read_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.line_load |-> FW'(rd_ptr) < fill_count)
    else $error("line read past the stored bytes");

  a_line_end_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.line_load && sts.line_last) |=> fill_count == '0)
    else $error("fill count not cleared after the line was emitted");

endmodule
